[src/hft_pkg.sv]
package hft_pkg;

	localparam int MaxDigitsDef = 48;
	localparam int DigW = 6;
	localparam int FracW = 60;
	localparam int MantW = 53;
	localparam int ExpW = 12;
	localparam int QueueDepth = 4;

	typedef struct packed {
		logic neg;
		logic spec;
		logic nan;
		logic up;
		logic dot;
		logic [1:0] lead;
		logic [DigW-1:0] digits;
		logic [FracW-1:0] frac;
		logic exp_neg;
		logic [1:0] exp_last;
		logic [3:0][3:0] exp_dig;
	} desc_t;

	typedef struct packed {
		logic valid;
		desc_t desc;
	} entry_t;

endpackage

[src/hft_in_if.sv]
interface hft_in_if;
	logic valid;
	logic ready;
	logic [63:0] value_bits;
	logic signed [6:0] digits_wanted;
	logic upper_case;
	logic alt_form;

	modport source(output valid, output value_bits, output digits_wanted,
		output upper_case, output alt_form, input ready);
	modport sink(input valid, input value_bits, input digits_wanted,
		input upper_case, input alt_form, output ready);
endinterface

[src/hft_out_if.sv]
interface hft_out_if;
	logic valid;
	logic ready;
	logic [7:0] text_char;
	logic last_char;

	modport source(output valid, output text_char, output last_char, input ready);
	modport sink(input valid, input text_char, input last_char, output ready);
endinterface

[src/hex_float_text_formatter.sv]
// Formats one IEEE binary64 value per input word as printf %a text.
// Input channel item carries value_bits, digits_wanted, upper_case and
// alt_form; it is taken when valid and ready are both high.
// Output channel text returns the text one ASCII character per word, with
// last_char set on the final character of each value.
// A six-stage front pipeline decodes, normalizes, rounds and converts the
// exponent to decimal, then places a descriptor in a four-entry queue.
// The back sequencer reads the queue head and emits one character per cycle
// while the receiver takes them. A descriptor passes the six front stages and
// a queue entry. A value's text has three or four characters for inf and nan,
// 20 to 24 for nonzero values at the default precision and up to 59 with 48
// fraction digits. Inputs are taken every cycle while the queue has
// room, so the character rate sets the sustained throughput. Reset empties
// the pipeline and the queue and drops any text in progress. When the receiver
// holds ready low the output character stays registered, the queue fills,
// and the front pipeline then drops item.ready.
module hex_float_text_formatter #(
	parameter int MAX_DIGITS = hft_pkg::MaxDigitsDef
) (
	input logic clk,
	input logic arst_n,
	hft_in_if.sink item,
	hft_out_if.source text
);
	import hft_pkg::*;

	entry_t push;
	entry_t head;
	logic push_ready;
	logic pop;

	hft_front #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.push(push),
		.push_ready(push_ready)
	);

	hft_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_ready(push_ready),
		.head(head),
		.pop(pop)
	);

	hft_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.text(text)
	);

endmodule

[src/hft_front.sv]
module hft_front #(
	parameter int MAX_DIGITS = hft_pkg::MaxDigitsDef
) (
	input logic clk,
	input logic arst_n,
	hft_in_if.sink item,
	output hft_pkg::entry_t push,
	input logic push_ready
);
	import hft_pkg::*;

	localparam logic [DigW-1:0] MaxP = DigW'(MAX_DIGITS);
	localparam logic [DigW-1:0] DefP = DigW'(13);
	localparam logic [ExpW-1:0] EBias = ExpW'(1023);
	localparam logic [ExpW-1:0] ESubBase = ExpW'(-1022);

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic [10:0] ef0;
	logic [51:0] fr0;
	logic zero0, sub0;
	logic [DigW-1:0] p0;
	logic [MantW-1:0] w0;
	logic [5:0] sh0;

	logic neg_s1, spec_s1, nan_s1, zero_s1, sub_s1, up_s1, alt_s1;
	logic [DigW-1:0] p_s1;
	logic [10:0] ef_s1;
	logic [MantW-1:0] w_s1;
	logic [5:0] sh_s1;

	logic [MantW-1:0] w2;
	logic [5:0] sh2;
	logic [ExpW-1:0] e2;

	logic neg_s2, spec_s2, nan_s2, zero_s2, up_s2, alt_s2;
	logic [DigW-1:0] p_s2;
	logic [MantW-1:0] m_s2;
	logic [ExpW-1:0] e_s2;

	logic [7:0] rnd_pos;
	logic [61:0] rnd3, big3, adj3;
	logic carry3;
	desc_t d3;
	logic [ExpW-1:0] e3;

	desc_t d_s3;
	logic zero_s3;
	logic [ExpW-1:0] e_s3;

	logic [ExpW-1:0] eabs4;
	logic [10:0] ae4;
	desc_t d4;
	logic th4;
	logic [9:0] r4;

	desc_t d_s4;
	logic th_s4;
	logic [9:0] r_s4;

	logic [3:0] h5;
	logic [6:0] r5;

	desc_t d_s5;
	logic th_s5;
	logic [3:0] h_s5;
	logic [6:0] r_s5;

	logic [3:0] t6, o6;
	desc_t d6;
	desc_t d_s6;

	assign en = !vld_s6 || push_ready;
	assign item.ready = en;
	assign push.valid = vld_s6;
	assign push.desc = d_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// Decode, digit count, and the coarse half of the subnormal normalizing shift.
	always_comb begin
		ef0 = item.value_bits[62:52];
		fr0 = item.value_bits[51:0];
		zero0 = (ef0 == '0) && (fr0 == '0);
		sub0 = (ef0 == '0) && (fr0 != '0);
		if (item.digits_wanted[6]) begin
			p0 = zero0 ? '0 : DefP;
		end else if (item.digits_wanted[5:0] > MaxP) begin
			p0 = MaxP;
		end else begin
			p0 = item.digits_wanted[5:0];
		end
		w0 = {(ef0 != '0), fr0};
		sh0 = '0;
		if (w0[MantW-1 -: 32] == '0) begin
			w0 = w0 << 32;
			sh0[5] = 1'b1;
		end
		if (w0[MantW-1 -: 16] == '0) begin
			w0 = w0 << 16;
			sh0[4] = 1'b1;
		end
		if (w0[MantW-1 -: 8] == '0) begin
			w0 = w0 << 8;
			sh0[3] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= item.value_bits[63];
			spec_s1 <= (ef0 == 11'h7FF);
			nan_s1 <= (ef0 == 11'h7FF) && (fr0 != '0);
			zero_s1 <= zero0;
			sub_s1 <= sub0;
			up_s1 <= item.upper_case;
			alt_s1 <= item.alt_form;
			p_s1 <= p0;
			ef_s1 <= ef0;
			w_s1 <= w0;
			sh_s1 <= sh0;
		end
	end

	always_comb begin
		w2 = w_s1;
		sh2 = sh_s1;
		if (w2[MantW-1 -: 4] == '0) begin
			w2 = w2 << 4;
			sh2[2] = 1'b1;
		end
		if (w2[MantW-1 -: 2] == '0) begin
			w2 = w2 << 2;
			sh2[1] = 1'b1;
		end
		if (w2[MantW-1] == 1'b0) begin
			w2 = w2 << 1;
			sh2[0] = 1'b1;
		end
		if (zero_s1) begin
			e2 = '0;
		end else if (sub_s1) begin
			e2 = ESubBase - {{(ExpW-6){1'b0}}, sh2};
		end else begin
			e2 = {{(ExpW-11){1'b0}}, ef_s1} - EBias;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2 <= neg_s1;
			spec_s2 <= spec_s1;
			nan_s2 <= nan_s1;
			zero_s2 <= zero_s1;
			up_s2 <= up_s1;
			alt_s2 <= alt_s1;
			p_s2 <= p_s1;
			m_s2 <= w2;
			e_s2 <= e2;
		end
	end

	// Rounds half up at last printed digit; carry to 2 renormalizes if p_s2 > 0.
	always_comb begin
		rnd_pos = 8'd59 - {p_s2, 2'b00};
		rnd3 = (p_s2 <= DigW'(14)) ? (62'd1 << rnd_pos) : '0;
		big3 = {1'b0, m_s2, 8'b0} + rnd3;
		carry3 = big3[61] && (p_s2 != '0);
		adj3 = carry3 ? (big3 >> 1) : big3;
		e3 = carry3 ? (e_s2 + ExpW'(1)) : e_s2;
		d3 = '0;
		d3.neg = neg_s2;
		d3.spec = spec_s2;
		d3.nan = nan_s2;
		d3.up = up_s2;
		d3.dot = (p_s2 != '0) || alt_s2;
		d3.lead = adj3[61:60];
		d3.digits = p_s2;
		d3.frac = adj3[FracW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s3 <= d3;
			zero_s3 <= zero_s2;
			e_s3 <= e3;
		end
	end

	always_comb begin
		eabs4 = e_s3[ExpW-1] ? (ExpW'(0) - e_s3) : e_s3;
		ae4 = eabs4[10:0];
		th4 = (ae4 >= 11'd1000);
		r4 = th4 ? 10'(ae4 - 11'd1000) : ae4[9:0];
		d4 = d_s3;
		d4.exp_neg = e_s3[ExpW-1];
		if (ae4 >= 11'd1000) begin
			d4.exp_last = 2'd3;
		end else if (ae4 >= 11'd100) begin
			d4.exp_last = 2'd2;
		end else if (ae4 >= 11'd10) begin
			d4.exp_last = 2'd1;
		end else begin
			d4.exp_last = 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s4 <= d4;
			th_s4 <= th4;
			r_s4 <= r4;
		end
	end

	always_comb begin
		h5 = '0;
		r5 = r_s4[6:0];
		for (int k = 1; k < 10; k++) begin
			if (r_s4 >= 10'(100 * k)) begin
				h5 = 4'(k);
				r5 = 7'(r_s4 - 10'(100 * k));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s5 <= d_s4;
			th_s5 <= th_s4;
			h_s5 <= h5;
			r_s5 <= r5;
		end
	end

	always_comb begin
		t6 = '0;
		o6 = r_s5[3:0];
		for (int k = 1; k < 10; k++) begin
			if (r_s5 >= 7'(10 * k)) begin
				t6 = 4'(k);
				o6 = 4'(r_s5 - 7'(10 * k));
			end
		end
		d6 = d_s5;
		d6.exp_dig[3] = {3'b000, th_s5};
		d6.exp_dig[2] = h_s5;
		d6.exp_dig[1] = t6;
		d6.exp_dig[0] = o6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s6 <= d6;
		end
	end

`ifndef SYNTHESIS
	a_lead_norm: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !d_s3.spec && !zero_s3 |-> d_s3.lead == 2'd1 || d_s3.lead == 2'd2)
		else $error("Rounded mantissa lost its normalized lead digit.");
`endif

endmodule

[src/hft_queue.sv]
module hft_queue (
	input logic clk,
	input logic arst_n,
	input hft_pkg::entry_t push,
	output logic push_ready,
	output hft_pkg::entry_t head,
	input logic pop
);
	import hft_pkg::*;

	localparam int PtrW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);

	desc_t mem_q [QueueDepth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] count_q;
	logic do_push;

	assign push_ready = (count_q != CntW'(QueueDepth));
	assign do_push = push.valid && push_ready;
	assign head.valid = (count_q != '0);
	assign head.desc = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push.desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
			end
			if (do_push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("Descriptor queue popped while empty.");
`endif

endmodule

[src/hft_back.sv]
module hft_back (
	input logic clk,
	input logic arst_n,
	input hft_pkg::entry_t head,
	output logic pop,
	hft_out_if.source text
);
	import hft_pkg::*;

	typedef enum logic [12:0] {
		PH_START = 13'b0000000000001,
		PH_SIGN  = 13'b0000000000010,
		PH_SP0   = 13'b0000000000100,
		PH_SP1   = 13'b0000000001000,
		PH_SP2   = 13'b0000000010000,
		PH_ZERO  = 13'b0000000100000,
		PH_X     = 13'b0000001000000,
		PH_LEAD  = 13'b0000010000000,
		PH_DOT   = 13'b0000100000000,
		PH_FRAC  = 13'b0001000000000,
		PH_PCH   = 13'b0010000000000,
		PH_ESIGN = 13'b0100000000000,
		PH_EXP   = 13'b1000000000000
	} phase_t;

	localparam int NibCnt = FracW / 4;

	function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic up);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'("0") + {4'b0000, nib};
		end else begin
			c = (up ? 8'("A") : 8'("a")) + {4'b0000, nib} - 8'd10;
		end
		return c;
	endfunction

	function automatic logic [3:0] frac_nib(input logic [FracW-1:0] f,
		input logic [DigW-1:0] idx);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < NibCnt; i++) begin
			if (idx == DigW'(i)) begin
				n = f[FracW-1-4*i -: 4];
			end
		end
		return n;
	endfunction

	phase_t phase_q, cur, nxt;
	logic [DigW-1:0] cnt_q, cnt_nxt;
	logic [7:0] char_q, ch;
	logic last_q, last, out_valid_q, emit;
	desc_t d;

	assign d = head.desc;
	assign emit = head.valid && (!out_valid_q || text.ready);
	assign pop = emit && last;
	assign text.valid = out_valid_q;
	assign text.text_char = char_q;
	assign text.last_char = last_q;

	always_comb begin
		if (phase_q == PH_START) begin
			cur = d.neg ? PH_SIGN : (d.spec ? PH_SP0 : PH_ZERO);
		end else begin
			cur = phase_q;
		end
		ch = 8'("0");
		last = 1'b0;
		nxt = PH_START;
		cnt_nxt = cnt_q;
		case (cur)
			PH_SIGN: begin
				ch = 8'("-");
				nxt = d.spec ? PH_SP0 : PH_ZERO;
			end
			PH_SP0: begin
				ch = d.nan ? (d.up ? 8'("N") : 8'("n")) : (d.up ? 8'("I") : 8'("i"));
				nxt = PH_SP1;
			end
			PH_SP1: begin
				ch = d.nan ? (d.up ? 8'("A") : 8'("a")) : (d.up ? 8'("N") : 8'("n"));
				nxt = PH_SP2;
			end
			PH_SP2: begin
				ch = d.nan ? (d.up ? 8'("N") : 8'("n")) : (d.up ? 8'("F") : 8'("f"));
				last = 1'b1;
			end
			PH_ZERO: begin
				ch = 8'("0");
				nxt = PH_X;
			end
			PH_X: begin
				ch = d.up ? 8'("X") : 8'("x");
				nxt = PH_LEAD;
			end
			PH_LEAD: begin
				ch = hex_char({2'b00, d.lead}, d.up);
				nxt = d.dot ? PH_DOT : PH_PCH;
			end
			PH_DOT: begin
				ch = 8'(".");
				nxt = (d.digits != '0) ? PH_FRAC : PH_PCH;
				cnt_nxt = '0;
			end
			PH_FRAC: begin
				ch = hex_char(frac_nib(d.frac, cnt_q), d.up);
				if (cnt_q == d.digits - DigW'(1)) begin
					nxt = PH_PCH;
				end else begin
					nxt = PH_FRAC;
					cnt_nxt = cnt_q + DigW'(1);
				end
			end
			PH_PCH: begin
				ch = d.up ? 8'("P") : 8'("p");
				nxt = PH_ESIGN;
			end
			PH_ESIGN: begin
				ch = d.exp_neg ? 8'("-") : 8'("+");
				nxt = PH_EXP;
				cnt_nxt = {{(DigW-2){1'b0}}, d.exp_last};
			end
			PH_EXP: begin
				ch = 8'("0") + {4'b0000, d.exp_dig[cnt_q[1:0]]};
				if (cnt_q[1:0] == 2'd0) begin
					last = 1'b1;
				end else begin
					nxt = PH_EXP;
					cnt_nxt = cnt_q - DigW'(1);
				end
			end
			default: begin
				last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				phase_q <= last ? PH_START : nxt;
				cnt_q <= cnt_nxt;
				out_valid_q <= 1'b1;
			end else if (text.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= ch;
			last_q <= last;
		end
	end

`ifndef SYNTHESIS
	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> text.valid && text.last_char)
		else $error("Descriptor released without its final character on the output.");
	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_START |-> head.valid)
		else $error("Text in progress but the descriptor queue is empty.");
	a_frac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FRAC |-> cnt_q < head.desc.digits)
		else $error("Fraction digit index ran past the digit count.");
`endif

endmodule
